### design/reno_gbn_window_controller_assert.svh
// Assertion macros shared by the window controller.
`ifndef RENO_GBN_WINDOW_CONTROLLER_ASSERT_SVH
`define RENO_GBN_WINDOW_CONTROLLER_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define RGBN_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rgbn assertion failed");

// An implication checked in the cycle after its trigger.
`define RGBN_ASSERT_NEXT(lbl, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error("rgbn assertion failed");

`endif

### design/rgbn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbn_pkg
// Shared codes, sizes and handshake structs of the Go-Back-N window controller.
// ----------------------------------------------------------------------------
package rgbn_pkg;

  localparam int MAX_WINDOW_DEF = 32;
  localparam int RUN_CAP        = 32;
  localparam int RUN_W          = 6;

  // Input operation codes.
  localparam logic [1:0] OP_SEND = 2'd0;
  localparam logic [1:0] OP_ACK  = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  // Result action codes.
  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_SEND   = 2'd1;
  localparam logic [1:0] ACT_RESEND = 2'd2;

  // Congestion phases.
  localparam logic [1:0] PH_SLOW  = 2'd0;
  localparam logic [1:0] PH_AVOID = 2'd1;
  localparam logic [1:0] PH_RECOV = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_TOTAL   = 3'd0;
  localparam logic [2:0] CFG_THRESH  = 3'd1;
  localparam logic [2:0] CFG_CREDIT  = 3'd2;
  localparam logic [2:0] CFG_WINDOW  = 3'd3;
  localparam logic [2:0] CFG_TIMEOUT = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
    logic adv;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic run_last;
  } status_t;

endpackage

### design/rgbn_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbn_datapath
// Window state, configuration, the item update and the result run.
// ----------------------------------------------------------------------------
module rgbn_datapath #(
  parameter int MAX_WINDOW = rgbn_pkg::MAX_WINDOW_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic [1:0]         op,
  input  logic [15:0]        ack_number,
  input  logic               ack_good,
  input  rgbn_pkg::cmd_t     cmd,
  output rgbn_pkg::status_t  status,
  output logic [1:0]         action,
  output logic [15:0]        packet_index,
  output logic               is_final,
  output logic               last,
  output logic [5:0]         window,
  output logic [1:0]         phase,
  output logic               done_res
);

  localparam int WW = $clog2(MAX_WINDOW + 1);
  localparam logic [WW-1:0] WMAX = WW'(MAX_WINDOW);
  localparam int RUN_W = rgbn_pkg::RUN_W;

  // Clamp a window value into 1..MAX_WINDOW.
  function automatic logic [WW-1:0] clampw(input logic [16:0] v);
    logic [WW-1:0] r;
    if (v == 17'd0) begin
      r = WW'(1);
    end else if (v > 17'(MAX_WINDOW)) begin
      r = WMAX;
    end else begin
      r = v[WW-1:0];
    end
    return r;
  endfunction

  // Effective send window from congestion window and credit.
  function automatic logic [WW-1:0] effw(input logic [WW-1:0] c, input logic [15:0] cr);
    logic [WW-1:0] r;
    if (16'(c) <= cr) begin
      r = c;
    end else begin
      r = cr[WW-1:0];
    end
    return r;
  endfunction

  logic [15:0] total_packets;
  logic [31:0] timeout_ticks;
  logic [16:0] base_index, next_index;
  logic [WW-1:0] cong_window, send_window;
  logic [15:0] threshold, credit, round_acks, recover_point;
  logic [2:0]  dup_count;
  logic [1:0]  phase_reg;
  logic [31:0] idle_timer;

  // Latched item.
  logic [1:0]  it_op;
  logic [15:0] it_ack;
  logic        it_good;

  // Result run.
  logic [1:0]       run_act;
  logic [16:0]      run_idx;
  logic [RUN_W-1:0] run_left;

  logic [16:0] base_next, next_next;
  logic [WW-1:0] cong_next, sw_next;
  logic [15:0] thr_next, cred_next, ra_next, rec_next;
  logic [2:0]  dup_next;
  logic [1:0]  ph_next, act_next;
  logic [31:0] tmr_next;
  logic [16:0] cnt;
  logic [16:0] ridx_next;
  logic [RUN_W-1:0] rleft_next;

  // Item update: the state after one item and the run it starts.
  always_comb begin
    logic fresh, rtx, full;
    fresh     = ({1'b0, it_ack} == base_index);
    rtx       = 1'b0;
    full      = 1'b0;
    base_next = base_index;
    next_next = next_index;
    cong_next = cong_window;
    sw_next   = send_window;
    thr_next  = threshold;
    cred_next = credit;
    ra_next   = round_acks;
    rec_next  = recover_point;
    dup_next  = dup_count;
    ph_next   = phase_reg;
    tmr_next  = idle_timer;
    act_next  = rgbn_pkg::ACT_NONE;
    ridx_next = 17'd0;
    rleft_next = RUN_W'(1);
    cnt       = 17'd0;
    if (base_index <= {1'b0, total_packets}) begin
      case (it_op)
        rgbn_pkg::OP_SEND: begin
          if ({1'b0, next_index} < {1'b0, base_index} + 18'(send_window) &&
              next_index <= {1'b0, total_packets}) begin
            act_next  = rgbn_pkg::ACT_SEND;
            ridx_next = next_index;
            next_next = next_index + 17'd1;
          end
        end
        rgbn_pkg::OP_ACK: begin
          if (it_good && !(fresh && base_index >= next_index)) begin
            if (phase_reg == rgbn_pkg::PH_SLOW || phase_reg == rgbn_pkg::PH_AVOID) begin
              if (fresh) begin
                if (phase_reg == rgbn_pkg::PH_SLOW) begin
                  if (16'(cong_window) < threshold) begin
                    cong_next = clampw(17'(cong_window) + 17'd1);
                  end else begin
                    ph_next = rgbn_pkg::PH_AVOID;
                  end
                end else begin
                  ra_next = round_acks + 16'd1;
                  if (ra_next >= 16'(cong_window)) begin
                    cong_next = clampw(17'(cong_window) + 17'd1);
                    ra_next   = 16'd0;
                  end
                end
              end else begin
                dup_next = dup_count + 3'd1;
                if (phase_reg == rgbn_pkg::PH_AVOID) begin
                  ra_next = 16'd0;
                end
              end
              if (!fresh && dup_next == 3'd3) begin
                rtx = 1'b1;
              end
            end else if (phase_reg == rgbn_pkg::PH_RECOV) begin
              if (fresh) begin
                if (it_ack >= recover_point) begin
                  ph_next   = rgbn_pkg::PH_AVOID;
                  cong_next = clampw({1'b0, threshold});
                end else begin
                  cong_next = clampw(17'(cong_window) + 17'd1);
                end
              end else begin
                dup_next  = dup_count + 3'd1;
                cong_next = clampw(17'(cong_window) + 17'd1);
                sw_next   = effw(cong_next, credit);
                if (dup_next == 3'd6) begin
                  full = 1'b1;
                end
              end
            end
            // Window slide on a new acknowledgement.
            if (fresh) begin
              dup_next  = 3'd0;
              base_next = base_index + 17'd1;
              cred_next = (credit != 16'd0) ? credit - 16'd1 : credit;
              sw_next   = effw(cong_next, cred_next);
              tmr_next  = 32'd0;
            end
          end
        end
        rgbn_pkg::OP_TICK: begin
          if (idle_timer != 32'hFFFF_FFFF) begin
            tmr_next = idle_timer + 32'd1;
          end
          if (tmr_next > timeout_ticks) begin
            full = 1'b1;
          end
        end
        default: begin
        end
      endcase
      // Fast retransmit enters recovery.
      if (rtx) begin
        tmr_next  = 32'd0;
        thr_next  = 16'(cong_next >> 1);
        cong_next = clampw(17'(thr_next) + 17'd3);
        sw_next   = effw(cong_next, cred_next);
        ph_next   = rgbn_pkg::PH_RECOV;
        if (next_index > base_index) begin
          rec_next = 16'(next_index - 17'd1);
        end
        dup_next  = 3'd0;
      end
      // Timeout or repeated loss restarts slow start.
      if (full) begin
        tmr_next  = 32'd0;
        thr_next  = 16'(cong_next >> 1);
        cong_next = WW'(1);
        dup_next  = 3'd0;
        sw_next   = effw(cong_next, cred_next);
        ph_next   = rgbn_pkg::PH_SLOW;
      end
      // Resend every outstanding index, at most one run length.
      if ((rtx || full) && next_index > base_index) begin
        act_next  = rgbn_pkg::ACT_RESEND;
        ridx_next = base_index;
        cnt       = next_index - base_index;
        rleft_next = (cnt > 17'(rgbn_pkg::RUN_CAP)) ? RUN_W'(rgbn_pkg::RUN_CAP)
                                                     : cnt[RUN_W-1:0];
      end
    end
  end

  // Control state, configuration and window state.
  always_ff @(posedge clk) begin
    if (rst) begin
      total_packets <= 16'd1;
      timeout_ticks <= 32'd200;
      base_index    <= 17'd1;
      next_index    <= 17'd1;
      cong_window   <= WW'(1);
      threshold     <= 16'd16;
      credit        <= 16'd2560;
      send_window   <= (MAX_WINDOW < 5) ? WMAX : WW'(5);
      dup_count     <= 3'd0;
      round_acks    <= 16'd0;
      phase_reg     <= rgbn_pkg::PH_SLOW;
      recover_point <= 16'd1;
      idle_timer    <= 32'd0;
      run_left      <= RUN_W'(1);
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rgbn_pkg::CFG_TOTAL:   total_packets <= cfg_data[15:0];
          rgbn_pkg::CFG_THRESH:  threshold     <= cfg_data[15:0];
          rgbn_pkg::CFG_CREDIT:  credit        <= cfg_data[15:0];
          rgbn_pkg::CFG_WINDOW: begin
            send_window <= (cfg_data[5:0] > 6'(MAX_WINDOW)) ? WMAX : WW'(cfg_data[5:0]);
          end
          rgbn_pkg::CFG_TIMEOUT: timeout_ticks <= cfg_data;
          default: begin
          end
        endcase
      end
      if (cmd.exec) begin
        base_index    <= base_next;
        next_index    <= next_next;
        cong_window   <= cong_next;
        send_window   <= sw_next;
        threshold     <= thr_next;
        credit        <= cred_next;
        round_acks    <= ra_next;
        recover_point <= rec_next;
        dup_count     <= dup_next;
        phase_reg     <= ph_next;
        idle_timer    <= tmr_next;
        run_left      <= rleft_next;
      end else if (cmd.adv) begin
        run_left <= run_left - RUN_W'(1);
      end
    end
  end

  // Item and run payload.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it_op   <= op;
      it_ack  <= ack_number;
      it_good <= ack_good;
    end
    if (cmd.exec) begin
      run_act <= act_next;
      run_idx <= ridx_next;
    end else if (cmd.adv) begin
      run_idx <= run_idx + 17'd1;
    end
  end

  // Result fields.
  assign status.run_last = (run_left == RUN_W'(1));
  assign action       = run_act;
  assign packet_index = run_idx[15:0];
  assign is_final     = (run_act != rgbn_pkg::ACT_NONE) && (run_idx == {1'b0, total_packets});
  assign last         = status.run_last;
  assign window       = 6'(send_window);
  assign phase        = phase_reg;
  assign done_res     = (base_index > {1'b0, total_packets});

endmodule

### design/rgbn_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbn_controller
// Sequencer: take an item, apply it, then hand out its results one by one.
// ----------------------------------------------------------------------------
module rgbn_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  rgbn_pkg::status_t status,
  output rgbn_pkg::cmd_t    cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0] state, state_next;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_EXEC;
      S_EXEC: state_next = S_EMIT;
      S_EMIT: if (out_ready && status.run_last) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Handshakes and datapath commands.
  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_EMIT);
  assign cmd.load  = in_ready && in_valid;
  assign cmd.exec  = (state == S_EXEC);
  assign cmd.adv   = out_valid && out_ready;

endmodule

### design/reno_gbn_window_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reno_gbn_window_controller
// Sender-side Go-Back-N window under Reno congestion control.
// ----------------------------------------------------------------------------
// One item is handled at a time: it is accepted, then applied to the window
// state in the next cycle, and its results then leave one per cycle while
// out_ready is high, as a single result or as a retransmit run of n indices
// (n at most 32); no new item is taken until the last result has left.
`include "reno_gbn_window_controller_assert.svh"

module reno_gbn_window_controller #(
  parameter int MAX_WINDOW = rgbn_pkg::MAX_WINDOW_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [15:0] ack_number,
  input  logic        ack_good,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  action,
  output logic [15:0] packet_index,
  output logic        is_final,
  output logic        last,
  output logic [5:0]  window,
  output logic [1:0]  phase,
  output logic        done_res
);

  rgbn_pkg::cmd_t    cmd;
  rgbn_pkg::status_t status;

  rgbn_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  rgbn_datapath #(.MAX_WINDOW(MAX_WINDOW)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .op           (op),
    .ack_number   (ack_number),
    .ack_good     (ack_good),
    .cmd          (cmd),
    .status       (status),
    .action       (action),
    .packet_index (packet_index),
    .is_final     (is_final),
    .last         (last),
    .window       (window),
    .phase        (phase),
    .done_res     (done_res)
  );

  // No new item is taken while results are pending.
  `RGBN_ASSERT(a_no_overlap, !(out_valid && in_ready))
  // The effective window never exceeds its ceiling.
  `RGBN_ASSERT(a_window_cap, window <= 6'(MAX_WINDOW))
  // A run that is not finished keeps presenting results.
  `RGBN_ASSERT_NEXT(a_run_cont, out_valid && out_ready && !last, out_valid)

endmodule
